FILE: design/line_editor_with_echo_unit_macros.svh
// Assertion helpers shared by the line editor RTL.
`ifndef LINE_EDITOR_WITH_ECHO_UNIT_MACROS_SVH
`define LINE_EDITOR_WITH_ECHO_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define LED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/led_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package led_pkg;

    // Line store geometry
    localparam int LINE_CAP = 32;
    localparam int ADDR_W   = $clog2(LINE_CAP);
    localparam int LEN_W    = 5;
    localparam int LIMIT_W  = 6;
    localparam int ECHO_W   = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Key codes
    localparam logic [7:0] KEY_ESC   = 8'h1B;
    localparam logic [7:0] KEY_BS    = 8'h08;
    localparam logic [7:0] KEY_CR    = 8'h0D;
    localparam logic [7:0] KEY_LF    = 8'h0A;
    localparam logic [7:0] KEY_DEL   = 8'h7F;
    localparam logic [7:0] KEY_BELL  = 8'h07;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_TILDE = 8'h7E;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;

    // Echo modes
    localparam logic [ECHO_W-1:0] ECHO_OFF  = 2'd0;
    localparam logic [ECHO_W-1:0] ECHO_STAR = 2'd2;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_LINE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DIGITS_ONLY = 2'd1;
    localparam logic [1:0] REG_ECHO_MODE   = 2'd2;

    localparam logic [LIMIT_W-1:0] RST_LINE_LIMIT = 6'd32;
    localparam logic [ECHO_W-1:0]  RST_ECHO_MODE  = 2'd1;

    typedef enum logic [1:0] {
        KIND_TERM  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_ABORT,
        OP_TERM,
        OP_ERASE,
        OP_ENTER
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic [ADDR_W-1:0] len;
        logic              echo;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qin;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic [LIMIT_W-1:0] line_limit;
        logic               digits_only;
        logic [ECHO_W-1:0]  echo_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ONE,
        B_ABORT,
        B_BS1,
        B_SP,
        B_BS2,
        B_CR,
        B_LF,
        B_LINE,
        B_DONE
    } t_bstate;

endpackage

`default_nettype wire

FILE: design/led_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: design/led_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Key classifier: owns the fill count, writes the line store, queues commands.
module led_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_key_valid,
    output logic                   o_key_ready,
    input  wire logic [7:0]        i_key_byte,
    input  wire led_pkg::t_cfg     i_cfg,
    input  wire logic              i_q_full,
    output led_pkg::t_qin          o_push,
    input  wire logic              i_line_done,
    output led_pkg::t_wr           o_wr
);

    localparam int CW = led_pkg::LIMIT_W + 1;

    logic [led_pkg::ADDR_W-1:0]  r_fill, n_fill;
    logic                        r_hold, n_hold;
    logic                        w_accept;
    logic [led_pkg::LIMIT_W-1:0] w_lim;
    logic                        w_room;
    logic                        w_echo;

    // Hold input from a line end until its completion result is issued
    assign o_key_ready = !r_hold && !i_q_full;
    assign w_accept    = i_key_valid && o_key_ready;
    assign w_echo      = (i_cfg.echo_mode != led_pkg::ECHO_OFF);

    // Effective line limit, clamped to [1, LINE_CAP]
    always_comb begin
        priority if (i_cfg.line_limit == '0) begin
            w_lim = led_pkg::LIMIT_W'(1);
        end else if (i_cfg.line_limit > led_pkg::LIMIT_W'(led_pkg::LINE_CAP)) begin
            w_lim = led_pkg::LIMIT_W'(led_pkg::LINE_CAP);
        end else begin
            w_lim = i_cfg.line_limit;
        end
    end

    // Room for one more char: fill + 1 < limit
    assign w_room = (CW'(r_fill) + CW'(1)) < CW'(w_lim);

    // Classification
    always_comb begin
        n_fill            = r_fill;
        n_hold            = r_hold;
        o_push.valid      = 1'b0;
        o_push.cmd.op     = led_pkg::OP_TERM;
        o_push.cmd.data   = led_pkg::KEY_BELL;
        o_push.cmd.len    = r_fill;
        o_push.cmd.echo   = w_echo;
        o_wr.en           = 1'b0;
        o_wr.addr         = r_fill;
        o_wr.data         = i_key_byte;

        if (i_line_done) begin
            n_hold = 1'b0;
        end

        if (w_accept) begin
            priority if (i_key_byte == led_pkg::KEY_ESC) begin
                o_push.valid  = 1'b1;
                o_push.cmd.op = led_pkg::OP_ABORT;
                n_fill        = '0;
            end else if (i_key_byte == led_pkg::KEY_BS || i_key_byte == led_pkg::KEY_DEL) begin
                if (r_fill != '0) begin
                    n_fill        = r_fill - led_pkg::ADDR_W'(1);
                    o_push.valid  = w_echo;
                    o_push.cmd.op = led_pkg::OP_ERASE;
                end else begin
                    o_push.valid  = 1'b1;
                end
            end else if (i_key_byte == led_pkg::KEY_CR || i_key_byte == led_pkg::KEY_LF) begin
                o_push.valid  = 1'b1;
                o_push.cmd.op = led_pkg::OP_ENTER;
                n_fill        = '0;
                n_hold        = 1'b1;
            end else if (i_cfg.digits_only &&
                         (i_key_byte < led_pkg::KEY_ZERO || i_key_byte > led_pkg::KEY_NINE)) begin
                o_push.valid  = 1'b1;
            end else if (i_key_byte < led_pkg::KEY_SPACE || i_key_byte > led_pkg::KEY_TILDE) begin
                o_push.valid  = 1'b1;
            end else if (w_room) begin
                o_wr.en         = 1'b1;
                n_fill          = r_fill + led_pkg::ADDR_W'(1);
                o_push.valid    = w_echo;
                o_push.cmd.data = (i_cfg.echo_mode == led_pkg::ECHO_STAR) ?
                                  led_pkg::KEY_STAR : i_key_byte;
            end else begin
                o_push.valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_hold <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_hold <= n_hold;
        end
    end

endmodule

`default_nettype wire

FILE: design/led_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Short command queue between classifier and sequencer.
module led_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire led_pkg::t_qin i_push,
    output logic               o_full,
    output led_pkg::t_qin      o_head,
    input  wire logic          i_pop
);

    led_pkg::t_cmd               r_mem [led_pkg::QDEPTH];
    logic [led_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [led_pkg::QCNT_W-1:0]  r_cnt;
    logic                        w_push, w_pop;

    assign o_full      = (r_cnt == led_pkg::QCNT_W'(led_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = i_pop && o_head.valid;

    function automatic logic [led_pkg::QPTR_W-1:0] f_inc(input logic [led_pkg::QPTR_W-1:0] p);
        f_inc = (p == led_pkg::QPTR_W'(led_pkg::QDEPTH - 1)) ? '0 : p + led_pkg::QPTR_W'(1);
    endfunction

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (w_pop) begin
                r_rp <= f_inc(r_rp);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + led_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - led_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/led_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Result sequencer: expands one command into its results, one per cycle while the result channel accepts.
module led_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire led_pkg::t_qin               i_head,
    output logic                             o_pop,
    output logic [led_pkg::ADDR_W-1:0]       o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output logic                             o_line_done,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output logic [1:0]                       o_result_kind,
    output logic [7:0]                       o_data_byte,
    output logic [led_pkg::LEN_W-1:0]        o_line_length,
    output logic                             o_final_of_run
);

    led_pkg::t_bstate            r_state, n_state, w_first;
    led_pkg::t_cmd               r_cmd;
    logic [led_pkg::ADDR_W-1:0]  r_idx, n_idx;
    logic                        w_slot;
    logic                        w_emit;
    led_pkg::t_kind              w_kind;
    logic [7:0]                  w_data;
    logic                        w_final;
    logic                        w_last;

    logic                        r_o_valid;
    led_pkg::t_kind              r_kind;
    logic [7:0]                  r_data;
    logic [led_pkg::LEN_W-1:0]   r_len;
    logic                        r_final;

    // Output register free to take a result
    assign w_slot = !r_o_valid || i_res_ready;
    assign w_last = ((r_idx + led_pkg::ADDR_W'(1)) == r_cmd.len);

    // First step of a freshly popped command
    always_comb begin
        unique case (i_head.cmd.op)
            led_pkg::OP_ABORT: w_first = led_pkg::B_ABORT;
            led_pkg::OP_TERM:  w_first = led_pkg::B_ONE;
            led_pkg::OP_ERASE: w_first = led_pkg::B_BS1;
            led_pkg::OP_ENTER: begin
                if (i_head.cmd.echo) begin
                    w_first = led_pkg::B_CR;
                end else if (i_head.cmd.len != '0) begin
                    w_first = led_pkg::B_LINE;
                end else begin
                    w_first = led_pkg::B_DONE;
                end
            end
            default: w_first = led_pkg::B_ONE;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            led_pkg::B_IDLE: begin
                if (i_head.valid) n_state = w_first;
            end
            led_pkg::B_ONE, led_pkg::B_ABORT, led_pkg::B_BS2, led_pkg::B_DONE: begin
                if (w_slot) n_state = led_pkg::B_IDLE;
            end
            led_pkg::B_BS1: begin
                if (w_slot) n_state = led_pkg::B_SP;
            end
            led_pkg::B_SP: begin
                if (w_slot) n_state = led_pkg::B_BS2;
            end
            led_pkg::B_CR: begin
                if (w_slot) n_state = led_pkg::B_LF;
            end
            led_pkg::B_LF: begin
                if (w_slot) n_state = (r_cmd.len != '0) ? led_pkg::B_LINE : led_pkg::B_DONE;
            end
            led_pkg::B_LINE: begin
                if (w_slot && w_last) n_state = led_pkg::B_DONE;
            end
            default: n_state = led_pkg::B_IDLE;
        endcase
    end

    // Per-state result and control
    always_comb begin
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_kind      = led_pkg::KIND_TERM;
        w_data      = '0;
        w_final     = 1'b0;
        o_line_done = 1'b0;
        n_idx       = r_idx;
        unique case (r_state)
            led_pkg::B_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid) n_idx = '0;
            end
            led_pkg::B_ONE: begin
                w_emit  = 1'b1;
                w_data  = r_cmd.data;
                w_final = 1'b1;
            end
            led_pkg::B_ABORT: begin
                w_emit  = 1'b1;
                w_kind  = led_pkg::KIND_ABORT;
                w_final = 1'b1;
            end
            led_pkg::B_BS1: begin
                w_emit = 1'b1;
                w_data = led_pkg::KEY_BS;
            end
            led_pkg::B_SP: begin
                w_emit = 1'b1;
                w_data = led_pkg::KEY_SPACE;
            end
            led_pkg::B_BS2: begin
                w_emit  = 1'b1;
                w_data  = led_pkg::KEY_BS;
                w_final = 1'b1;
            end
            led_pkg::B_CR: begin
                w_emit = 1'b1;
                w_data = led_pkg::KEY_CR;
            end
            led_pkg::B_LF: begin
                w_emit = 1'b1;
                w_data = led_pkg::KEY_LF;
            end
            led_pkg::B_LINE: begin
                w_emit = 1'b1;
                w_kind = led_pkg::KIND_LINE;
                w_data = i_rdata;
                if (w_slot && !w_last) n_idx = r_idx + led_pkg::ADDR_W'(1);
            end
            led_pkg::B_DONE: begin
                w_emit      = 1'b1;
                w_kind      = led_pkg::KIND_DONE;
                w_final     = 1'b1;
                o_line_done = w_slot;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Store is addressed with the next index, so its registered read data lines up with the current index
    assign o_raddr = n_idx;

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= led_pkg::B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_slot) begin
                r_o_valid <= w_emit;
            end
        end
    end

    // Command and payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_cmd <= i_head.cmd;
        end
        if (w_slot && w_emit) begin
            r_kind  <= w_kind;
            r_data  <= w_data;
            r_len   <= (w_kind == led_pkg::KIND_DONE) ? led_pkg::LEN_W'(r_cmd.len) : '0;
            r_final <= w_final;
        end
    end

    assign o_res_valid    = r_o_valid;
    assign o_result_kind  = r_kind;
    assign o_data_byte    = r_data;
    assign o_line_length  = r_len;
    assign o_final_of_run = r_final;

endmodule

`default_nettype wire

FILE: design/line_editor_with_echo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "line_editor_with_echo_unit_macros.svh"

// Line editor with echo. Keyboard bytes enter on the key channel and leave as
// terminal echo bytes, bells, stored line bytes and line complete/aborted
// results on the result channel; the last result of each key has
// o_final_of_run set, and a key may cause no result at all when echo is off.
// A classifier takes a key and queues a command (two-entry queue); a sequencer
// turns each command into one result per cycle while the result channel
// accepts them. A line end walks the stored characters out of the line store
// one per cycle, as results are accepted, through its registered read port,
// and no new key is taken until the completion result has been issued. No
// clearing pass is needed after reset.
// Registers via APB at 0x0 line_limit, 0x4 digits_only, 0x8 echo_mode.
module line_editor_with_echo_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // key channel
    input  wire logic                          i_key_valid,
    output logic                               o_key_ready,
    input  wire logic [7:0]                    i_key_byte,
    // result channel
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [1:0]                         o_result_kind,
    output logic [7:0]                         o_data_byte,
    output logic [led_pkg::LEN_W-1:0]          o_line_length,
    output logic                               o_final_of_run,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [led_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [led_pkg::PDATA_W-1:0]   pwdata,
    output logic [led_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    led_pkg::t_cfg              r_cfg;
    led_pkg::t_qin              w_push;
    led_pkg::t_qin              w_head;
    led_pkg::t_wr               w_wr;
    logic                       w_q_full;
    logic                       w_pop;
    logic                       w_line_done;
    logic [led_pkg::ADDR_W-1:0] w_raddr;
    logic [7:0]                 w_rdata;
    logic                       w_cfg_wr;
    logic                       w_out_line;
    logic                       w_out_close;
    logic                       w_out_plain;
    logic                       w_done_free;
    logic                       w_key_side;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_limit  <= led_pkg::RST_LINE_LIMIT;
            r_cfg.digits_only <= 1'b0;
            r_cfg.echo_mode   <= led_pkg::RST_ECHO_MODE;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                led_pkg::REG_LINE_LIMIT:  r_cfg.line_limit  <= pwdata[led_pkg::LIMIT_W-1:0];
                led_pkg::REG_DIGITS_ONLY: r_cfg.digits_only <= pwdata[0];
                led_pkg::REG_ECHO_MODE:   r_cfg.echo_mode   <= pwdata[led_pkg::ECHO_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            led_pkg::REG_LINE_LIMIT:  prdata = led_pkg::PDATA_W'(r_cfg.line_limit);
            led_pkg::REG_DIGITS_ONLY: prdata = led_pkg::PDATA_W'(r_cfg.digits_only);
            led_pkg::REG_ECHO_MODE:   prdata = led_pkg::PDATA_W'(r_cfg.echo_mode);
            default:                  prdata = '0;
        endcase
    end

    led_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (i_key_valid),
        .o_key_ready (o_key_ready),
        .i_key_byte  (i_key_byte),
        .i_cfg       (r_cfg),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .i_line_done (w_line_done),
        .o_wr        (w_wr)
    );

    led_ram #(
        .WIDTH (8),
        .DEPTH (led_pkg::LINE_CAP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    led_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    led_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_line_done    (w_line_done),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_line_length  (o_line_length),
        .o_final_of_run (o_final_of_run)
    );

    // Result classes watched by the checks below
    assign w_out_line  = o_res_valid && (o_result_kind == led_pkg::KIND_LINE);
    assign w_out_close = o_res_valid && (o_result_kind == led_pkg::KIND_DONE ||
                                         o_result_kind == led_pkg::KIND_ABORT);
    assign w_out_plain = o_res_valid && (o_result_kind != led_pkg::KIND_DONE);
    assign w_done_free = w_line_done && !w_q_full;
    assign w_key_side  = o_key_ready || w_q_full;

    // Keys stay blocked while a finished line is still streaming out
    `LED_ASSERT_NOW(a_line_blocks_keys, i_clk, i_rst_n, w_out_line, !o_key_ready, "key in line")
    // Completion and abort always close a key's run
    `LED_ASSERT_NOW(a_done_is_final, i_clk, i_rst_n, w_out_close, o_final_of_run, "not final")
    // Length field only carried by a completion
    `LED_ASSERT_NOW(a_len_only_done, i_clk, i_rst_n, w_out_plain, ~|o_line_length, "stray length")
    // A completion issued frees the key side on the next cycle unless the queue is full
    `LED_ASSERT_NEXT(a_done_releases, i_clk, i_rst_n, w_done_free, w_key_side, "key side held")

endmodule

`default_nettype wire
